### hdl/lgts_pkg.sv
// shared types, constants and codes of the light grid sampler
package lgts_pkg;

   localparam int MAX_AXIS_DEF   = 16;
   localparam int GRID_DEPTH_DEF = 4096;

   // field widths
   localparam int SIZE_W   = 5;
   localparam int FRAC_W   = 9;
   localparam int IDX_W    = 15;
   localparam int ENTRY_W  = 12;
   localparam int VAL_W    = 16;
   localparam int REQ_W    = 160;
   localparam int RSP_W    = 96;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;
   localparam int CNT_W    = 5;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // iteration counts and direction scale of the back end
   localparam int CORNERS    = 8;
   localparam int SQRT_STEPS = 25;
   localparam int DIV_STEPS  = 15;
   localparam int DIR_ONE    = 16384;

   // operation codes of an input transfer
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      REG_ORIGIN_X   = 3'd0,
      REG_ORIGIN_Y   = 3'd1,
      REG_ORIGIN_Z   = 3'd2,
      REG_SIZE_X     = 3'd3,
      REG_SIZE_Y     = 3'd4,
      REG_SIZE_Z     = 3'd5,
      REG_AMBIENT    = 3'd6,
      REG_GRID_READY = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_LOAD     = 2'd0,
      KIND_QUERY    = 2'd1,
      KIND_FALLBACK = 2'd2
   } kind_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_GATHER = 6'b000010,
      ST_SCALE  = 6'b000100,
      ST_SQRT   = 6'b001000,
      ST_DIVIDE = 6'b010000,
      ST_SEND   = 6'b100000
   } state_type;

   typedef struct packed {
      logic [2:0][VAL_W-1:0]  origin;
      logic [2:0][SIZE_W-1:0] size;
      logic [VAL_W-1:0]       ambient;
      logic                   grid_ready;
   } cfg_type;

   typedef struct packed {
      logic [SIZE_W-1:0] c0;
      logic [SIZE_W-1:0] c1;
      logic [FRAC_W-1:0] t;
   } axis_type;

   typedef struct packed {
      kind_type              kind;
      logic [ENTRY_W-1:0]    entry_index;
      logic [2:0][VAL_W-1:0] color;
      logic [2:0][VAL_W-1:0] dir;
      axis_type [2:0]        axis;
   } job_type;

   typedef struct packed {
      logic                  fallback;
      logic [2:0][VAL_W-1:0] dir;
      logic [2:0][VAL_W-1:0] color;
   } light_type;

endpackage

### hdl/lgts_ram.sv
// generic single write port, single read port ram with registered read
module lgts_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/lgts_front.sv
// front end: classifies transfers and works out corners and fractions of queries
module lgts_front
   import lgts_pkg::*;
#(
   parameter int MAX_AXIS   = MAX_AXIS_DEF,
   parameter int GRID_DEPTH = GRID_DEPTH_DEF
) (
   input  logic                  op,
   input  logic [ENTRY_W-1:0]    entry_index,
   input  logic [2:0][VAL_W-1:0] color,
   input  logic [2:0][VAL_W-1:0] dir,
   input  logic [2:0][VAL_W-1:0] point,
   input  cfg_type               cfg,
   output job_type               job
);

   logic [2:0][16:0]       rel;
   logic [2:0][12:0]       hi;
   logic [2:0][12:0]       rc;
   logic [2:0][SIZE_W-1:0] cap;
   logic [2:0][SIZE_W-1:0] lo;
   logic [2:0][12:0]       frac;
   logic [9:0]             prod_yz;
   logic [14:0]            product;
   logic                   usable;

   // grid usability from the sizes
   always_comb begin
      usable = cfg.grid_ready;
      for (int i = 0; i < 3; i++) begin
         if (cfg.size[i] == '0 || {27'd0, cfg.size[i]} > MAX_AXIS) begin
            usable = 1'b0;
         end
      end
      prod_yz = 10'(cfg.size[1]) * 10'(cfg.size[2]);
      product = 15'(cfg.size[0]) * 15'(prod_yz);
      if ({17'd0, product} > GRID_DEPTH) begin
         usable = 1'b0;
      end
   end

   // per axis clamp, low corner and fraction
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rel[i] = {point[i][15], point[i]} - {cfg.origin[i][15], cfg.origin[i]};
         hi[i]  = {cfg.size[i] - 5'd1, 8'd0};
         if (rel[i][16]) begin
            rc[i] = '0;
         end else if (rel[i][15:0] > {3'd0, hi[i]}) begin
            rc[i] = hi[i];
         end else begin
            rc[i] = rel[i][12:0];
         end
         cap[i] = (cfg.size[i] >= 5'd2) ? cfg.size[i] - 5'd2 : '0;
         lo[i]  = (rc[i][12:8] > cap[i]) ? cap[i] : rc[i][12:8];
         frac[i] = rc[i] - {lo[i], 8'd0};
      end
   end

   // assemble the queue entry
   always_comb begin
      job.entry_index = entry_index;
      job.color       = color;
      job.dir         = dir;
      for (int i = 0; i < 3; i++) begin
         job.axis[i].c0 = lo[i];
         job.axis[i].c1 = ({1'b0, lo[i]} + 6'd1 < {1'b0, cfg.size[i]}) ?
                          lo[i] + 5'd1 : cfg.size[i] - 5'd1;
         job.axis[i].t  = frac[i][FRAC_W-1:0];
      end
      if (op == OP_LOAD) begin
         job.kind = KIND_LOAD;
      end else if (usable) begin
         job.kind = KIND_QUERY;
      end else begin
         job.kind = KIND_FALLBACK;
      end
   end

endmodule

### hdl/lgts_queue.sv
// short queue of classified transfers between front and back
module lgts_queue
   import lgts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head,
   output logic    full,
   output logic    empty
);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   assign head  = slot_ff[rd_ff];
   assign full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W + 1)'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |-> !push)
      else $error("transfer pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("transfer popped from empty queue");
`endif

endmodule

### hdl/lgts_back.sv
// back end: grid stores, corner gather, blend and direction normaliser
module lgts_back
   import lgts_pkg::*;
#(
   parameter int GRID_DEPTH = GRID_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  job_type   job,
   input  logic      job_valid,
   output logic      job_pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output light_type rsp_light
);

   localparam int AW = $clog2(GRID_DEPTH);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   axis_type [2:0]         geo_ff, geo_in;
   logic                   fallback_ff, fallback_in;
   logic                   zero_ff, zero_in;
   logic                   a_valid_ff, a_valid_in;
   logic                   b_valid_ff, b_valid_in;
   logic [17:0]            wxy_ff, wxy_in;
   logic [FRAC_W-1:0]      wz_ff, wz_in;
   logic [24:0]            w_ff, w_in;
   logic [2:0][VAL_W-1:0]  cdat_ff, cdat_in;
   logic [2:0][VAL_W-1:0]  ddat_ff, ddat_in;
   logic [40:0]            csum_ff [3];
   logic [40:0]            csum_in [3];
   logic signed [41:0]     dsum_ff [3];
   logic signed [41:0]     dsum_in [3];
   logic signed [VAL_W-1:0] dval [3];
   logic [39:0]            mag_ff [3];
   logic [39:0]            mag_in [3];
   logic [2:0]             neg_ff, neg_in;
   logic [49:0]            rad_ff, rad_in;
   logic [27:0]            rem_ff, rem_in;
   logic [24:0]            root_ff, root_in;
   logic [39:0]            num_ff [3];
   logic [39:0]            num_in [3];
   logic [39:0]            dsh_ff, dsh_in;
   logic [14:0]            quo_ff [3];
   logic [14:0]            quo_in [3];
   logic                   rsp_valid_ff, rsp_valid_in;
   light_type              rsp_ff, rsp_in;

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr, ram_raddr;
   logic [2:0][VAL_W-1:0]  color_rdata, dir_rdata;

   lgts_ram #(.WIDTH(3 * VAL_W), .DEPTH(GRID_DEPTH)) u_color_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (job.color),
      .raddr (ram_raddr),
      .rdata (color_rdata)
   );

   lgts_ram #(.WIDTH(3 * VAL_W), .DEPTH(GRID_DEPTH)) u_direction_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (job.dir),
      .raddr (ram_raddr),
      .rdata (dir_rdata)
   );

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dval[j] = ddat_ff[j];
      end
   end

   // sequencer
   always_comb begin
      logic [2:0]        k;
      logic [SIZE_W-1:0] cx, cy, cz;
      logic [FRAC_W-1:0] wx, wy;
      logic [9:0]        stride;
      logic [IDX_W-1:0]  idx;
      logic [26:0]       wfull;
      logic [39:0]       mx;
      logic [27:0]       rem_n, trial;
      logic [41:0]       cround;
      light_type         res;

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      geo_in       = geo_ff;
      fallback_in  = fallback_ff;
      zero_in      = zero_ff;
      a_valid_in   = 1'b0;
      wxy_in       = wxy_ff;
      wz_in        = wz_ff;
      neg_in       = neg_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      dsh_in       = dsh_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      for (int j = 0; j < 3; j++) begin
         csum_in[j] = csum_ff[j];
         dsum_in[j] = dsum_ff[j];
         mag_in[j]  = mag_ff[j];
         num_in[j]  = num_ff[j];
         quo_in[j]  = quo_ff[j];
      end
      job_pop   = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = AW'(job.entry_index);

      // corner address and partial weight
      k      = cnt_ff[2:0];
      cx     = k[0] ? geo_ff[0].c1 : geo_ff[0].c0;
      cy     = k[1] ? geo_ff[1].c1 : geo_ff[1].c0;
      cz     = k[2] ? geo_ff[2].c1 : geo_ff[2].c0;
      wx     = k[0] ? geo_ff[0].t : 9'd256 - geo_ff[0].t;
      wy     = k[1] ? geo_ff[1].t : 9'd256 - geo_ff[1].t;
      stride = 10'(cfg.size[1]) * 10'(cfg.size[2]);
      idx    = 15'(cx) * 15'(stride) + 15'(cy) * 15'(cfg.size[2]) + 15'(cz);
      ram_raddr = ({17'd0, idx} < GRID_DEPTH) ? AW'(idx) : '0;

      // full weight and read data of the previous corner
      b_valid_in = a_valid_ff;
      wfull      = 27'(wxy_ff) * 27'(wz_ff);
      w_in       = wfull[24:0];
      cdat_in    = color_rdata;
      ddat_in    = dir_rdata;

      // weighted accumulation
      if (b_valid_ff) begin
         for (int j = 0; j < 3; j++) begin
            csum_in[j] = csum_ff[j] + 41'(w_ff) * 41'(cdat_ff[j]);
            dsum_in[j] = dsum_ff[j] + $signed({1'b0, w_ff}) * dval[j];
         end
      end

      // largest direction magnitude
      mx = mag_ff[0];
      if (mag_ff[1] > mx) mx = mag_ff[1];
      if (mag_ff[2] > mx) mx = mag_ff[2];

      // square root step
      rem_n = {rem_ff[25:0], rad_ff[49:48]};
      trial = {1'b0, root_ff, 2'b01};

      // finished result
      cround = {1'b0, csum_ff[0]} + 42'h80_0000;
      res.color[0] = cround[39:24];
      cround = {1'b0, csum_ff[1]} + 42'h80_0000;
      res.color[1] = cround[39:24];
      cround = {1'b0, csum_ff[2]} + 42'h80_0000;
      res.color[2] = cround[39:24];
      res.fallback = fallback_ff;
      for (int j = 0; j < 3; j++) begin
         if (fallback_ff || zero_ff) begin
            res.dir[j] = '0;
         end else if (neg_ff[j]) begin
            res.dir[j] = 16'd0 - {1'b0, quo_ff[j]};
         end else begin
            res.dir[j] = {1'b0, quo_ff[j]};
         end
         if (fallback_ff) begin
            res.color[j] = cfg.ambient;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               unique case (job.kind)
                  KIND_LOAD: begin
                     ram_we = ({20'd0, job.entry_index} < GRID_DEPTH);
                  end
                  KIND_QUERY: begin
                     geo_in      = job.axis;
                     cnt_in      = '0;
                     fallback_in = 1'b0;
                     zero_in     = 1'b0;
                     for (int j = 0; j < 3; j++) begin
                        csum_in[j] = '0;
                        dsum_in[j] = '0;
                     end
                     state_in = ST_GATHER;
                  end
                  KIND_FALLBACK: begin
                     fallback_in = 1'b1;
                     state_in    = ST_SEND;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_GATHER: begin
            if (cnt_ff < CNT_W'(CORNERS)) begin
               a_valid_in = 1'b1;
               wxy_in     = 18'(wx) * 18'(wy);
               wz_in      = k[2] ? geo_ff[2].t : 9'd256 - geo_ff[2].t;
               cnt_in     = cnt_ff + 1'b1;
            end else if (!a_valid_ff && !b_valid_ff) begin
               for (int j = 0; j < 3; j++) begin
                  neg_in[j] = dsum_ff[j][41];
                  mag_in[j] = dsum_ff[j][41] ? 40'(-dsum_ff[j]) : 40'(dsum_ff[j]);
               end
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            priority if (mx == '0) begin
               zero_in  = 1'b1;
               state_in = ST_SEND;
            end else if (mx >= 40'h01_0000_0000) begin
               for (int j = 0; j < 3; j++) mag_in[j] = mag_ff[j] >> 8;
            end else if (mx >= 40'h00_0100_0000) begin
               for (int j = 0; j < 3; j++) mag_in[j] = mag_ff[j] >> 1;
            end else if (mx < 40'h00_0000_8000) begin
               for (int j = 0; j < 3; j++) mag_in[j] = mag_ff[j] << 8;
            end else if (mx < 40'h00_0080_0000) begin
               for (int j = 0; j < 3; j++) mag_in[j] = mag_ff[j] << 1;
            end else begin
               rad_in = 50'(mag_ff[0][23:0]) * 50'(mag_ff[0][23:0])
                      + 50'(mag_ff[1][23:0]) * 50'(mag_ff[1][23:0])
                      + 50'(mag_ff[2][23:0]) * 50'(mag_ff[2][23:0]);
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (rem_n >= trial) begin
               rem_in  = rem_n - trial;
               root_in = {root_ff[23:0], 1'b1};
            end else begin
               rem_in  = rem_n;
               root_in = {root_ff[23:0], 1'b0};
            end
            rad_in = {rad_ff[47:0], 2'b00};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
               for (int j = 0; j < 3; j++) begin
                  num_in[j] = 40'({mag_ff[j][23:0], 15'd0}) + 40'(root_in);
                  quo_in[j] = '0;
               end
               dsh_in   = {root_in, 15'd0};
               cnt_in   = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            for (int j = 0; j < 3; j++) begin
               if (num_ff[j] >= dsh_ff) begin
                  num_in[j] = num_ff[j] - dsh_ff;
                  quo_in[j] = {quo_ff[j][13:0], 1'b1};
               end else begin
                  quo_in[j] = {quo_ff[j][13:0], 1'b0};
               end
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res;
               rsp_valid_in = 1'b1;
               fallback_in  = 1'b0;
               zero_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         fallback_ff  <= 1'b0;
         zero_ff      <= 1'b0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fallback_ff  <= fallback_in;
         zero_ff      <= zero_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      geo_ff  <= geo_in;
      wxy_ff  <= wxy_in;
      wz_ff   <= wz_in;
      w_ff    <= w_in;
      cdat_ff <= cdat_in;
      ddat_ff <= ddat_in;
      neg_ff  <= neg_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      dsh_ff  <= dsh_in;
      rsp_ff  <= rsp_in;
      for (int j = 0; j < 3; j++) begin
         csum_ff[j] <= csum_in[j];
         dsum_ff[j] <= dsum_in[j];
         mag_ff[j]  <= mag_in[j];
         num_ff[j]  <= num_in[j];
         quo_ff[j]  <= quo_in[j];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_light = rsp_ff;

`ifndef ASSERT_OFF
   a_gather_only: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff || b_valid_ff) |-> state_ff == ST_GATHER)
      else $error("corner read in flight outside gather");
   a_sqrt_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQRT |-> {1'b0, rem_ff} <= {3'd0, root_ff, 1'b0})
      else $error("square root remainder out of bound");
   a_unit_quotient: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEND && !fallback_ff && !zero_ff |->
         quo_ff[0] <= 15'(DIR_ONE) && quo_ff[1] <= 15'(DIR_ONE) &&
         quo_ff[2] <= 15'(DIR_ONE))
      else $error("normalised direction above one");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> state_ff == ST_IDLE || state_ff == ST_GATHER ||
                  state_ff == ST_SEND)
      else $error("queue popped outside idle");
`endif

endmodule

### hdl/light_grid_trilinear_sampler.sv
// top level of the light grid trilinear sampler
//
// Channels: req_ carries load and query transfers (req_tuser is the op,
// 0 load, 1 query); rsp_ returns one light sample per query and nothing
// for a load. The csr_ port sets the grid origin, sizes, ambient level and
// the grid ready flag; write it only while no transfer is in flight.
// A front end classifies each input transfer into a four entry queue, so
// req_tready stays high while the queue has room. The back end writes a
// load into both stores. A query gathers its 8 corners from the colour and
// direction stores, rescales the blended direction, takes a bitwise square
// root and divides bitwise before its result is registered; a query with a
// zero blended direction skips the root and divide, and a fallback query
// goes straight to its result. The back end starts the next item only once
// the result is registered, so the sqrt and divide loops set the query
// rate. Results sit
// in an output register; while the receiver stalls the back end holds its
// next result and the queue keeps filling. Reset clears the queue, the
// sequencer and all configuration registers; the stores are not cleared,
// so every grid entry must be loaded before it is sampled.
module light_grid_trilinear_sampler
   import lgts_pkg::*;
#(
   parameter int MAX_AXIS   = MAX_AXIS_DEF,
   parameter int GRID_DEPTH = GRID_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // entry_index, color_red, color_green, color_blue, dir_x, dir_y, dir_z,
   // point_x, point_y, point_z, zero fill
   input  logic [REQ_W-1:0]  req_tdata,
   // op
   input  logic              req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // light_red, light_green, light_blue, light_dir_x, light_dir_y, light_dir_z
   output logic [RSP_W-1:0]  rsp_tdata,
   // used_fallback
   output logic              rsp_tuser,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type               cfg_ff, cfg_in;
   reg_index_type         csr_index;
   logic                  csr_write;
   logic [2:0][VAL_W-1:0] color, dir, point;
   job_type               front_job, head_job;
   logic                  q_full, q_empty, q_pop;
   light_type             light;

   // configuration registers
   assign csr_index  = reg_index_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_ORIGIN_X:   cfg_in.origin[0]  = csr_pwdata[VAL_W-1:0];
            REG_ORIGIN_Y:   cfg_in.origin[1]  = csr_pwdata[VAL_W-1:0];
            REG_ORIGIN_Z:   cfg_in.origin[2]  = csr_pwdata[VAL_W-1:0];
            REG_SIZE_X:     cfg_in.size[0]    = csr_pwdata[SIZE_W-1:0];
            REG_SIZE_Y:     cfg_in.size[1]    = csr_pwdata[SIZE_W-1:0];
            REG_SIZE_Z:     cfg_in.size[2]    = csr_pwdata[SIZE_W-1:0];
            REG_AMBIENT:    cfg_in.ambient    = csr_pwdata[VAL_W-1:0];
            REG_GRID_READY: cfg_in.grid_ready = csr_pwdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read back
   always_comb begin
      unique case (csr_index)
         REG_ORIGIN_X:   csr_prdata = CSR_DW'(cfg_ff.origin[0]);
         REG_ORIGIN_Y:   csr_prdata = CSR_DW'(cfg_ff.origin[1]);
         REG_ORIGIN_Z:   csr_prdata = CSR_DW'(cfg_ff.origin[2]);
         REG_SIZE_X:     csr_prdata = CSR_DW'(cfg_ff.size[0]);
         REG_SIZE_Y:     csr_prdata = CSR_DW'(cfg_ff.size[1]);
         REG_SIZE_Z:     csr_prdata = CSR_DW'(cfg_ff.size[2]);
         REG_AMBIENT:    csr_prdata = CSR_DW'(cfg_ff.ambient);
         REG_GRID_READY: csr_prdata = CSR_DW'(cfg_ff.grid_ready);
         default:        csr_prdata = '0;
      endcase
   end

   // unpack the input transfer
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         color[j] = req_tdata[12 + 16 * j +: 16];
         dir[j]   = req_tdata[60 + 16 * j +: 16];
         point[j] = req_tdata[108 + 16 * j +: 16];
      end
   end

   lgts_front #(.MAX_AXIS(MAX_AXIS), .GRID_DEPTH(GRID_DEPTH)) u_front (
      .op          (req_tuser),
      .entry_index (req_tdata[ENTRY_W-1:0]),
      .color       (color),
      .dir         (dir),
      .point       (point),
      .cfg         (cfg_ff),
      .job         (front_job)
   );

   assign req_tready = !q_full;

   lgts_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_tvalid && !q_full),
      .push_job (front_job),
      .pop      (q_pop),
      .head     (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   lgts_back #(.GRID_DEPTH(GRID_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job       (head_job),
      .job_valid (!q_empty),
      .job_pop   (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_light (light)
   );

   // pack the result transfer
   assign rsp_tdata = {light.dir[2], light.dir[1], light.dir[0],
                       light.color[2], light.color[1], light.color[0]};
   assign rsp_tuser = light.fallback;

endmodule

### tb/testbench.sv
// self-checking testbench for the light grid trilinear sampler
module testbench
   import lgts_pkg::*;
();

   // holds the shadow grid, the shadow registers and the samples still owed by the block
   class light_sample_checker;
      bit [15:0] colour_mem [0:4095][0:2];
      bit [15:0] dir_mem [0:4095][0:2];
      bit        loaded [0:4095];
      bit [15:0] origin [0:2];
      bit [4:0]  size [0:2];
      bit [15:0] ambient;
      bit        ready;
      light_type awaited_samples [$];
      int        mismatches;

      function void write_reg(reg_index_type idx, bit [31:0] value);
         case (idx)
            REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z: origin[idx] = value[15:0];
            REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z: size[idx - REG_SIZE_X] = value[4:0];
            REG_AMBIENT: ambient = value[15:0];
            REG_GRID_READY: ready = value[0];
            default: ;
         endcase
      endfunction

      function bit grid_usable();
         longint prod;
         bit ok;
         prod = 1;
         ok = ready;
         for (int i = 0; i < 3; i++) begin
            if (size[i] == 0 || size[i] > MAX_AXIS_DEF) ok = 0;
            prod *= size[i];
         end
         if (prod > GRID_DEPTH_DEF) ok = 0;
         return ok;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      // trilinear blend of the eight corners around a point
      function light_type sample_light(bit [15:0] pt [0:2]);
         light_type s;
         int n, hi, r, lo, cap;
         int c0 [0:2], c1 [0:2], t [0:2];
         int cx, cy, cz, idx;
         longint w;
         longint unsigned csum [0:2], a [0:2], m, sq, len, q;
         longint dsum [0:2];
         bit neg [0:2];
         s = '0;
         if (!grid_usable()) begin
            for (int j = 0; j < 3; j++) s.color[j] = ambient;
            s.fallback = 1'b1;
            return s;
         end
         for (int i = 0; i < 3; i++) begin
            n = size[i];
            hi = (n - 1) * 256;
            r = int'($signed(pt[i])) - int'($signed(origin[i]));
            cap = (n - 2 > 0) ? n - 2 : 0;
            if (r < 0) r = 0;
            if (r > hi) r = hi;
            lo = r / 256;
            if (lo > cap) lo = cap;
            c0[i] = lo;
            c1[i] = (lo + 1 < n) ? lo + 1 : n - 1;
            t[i] = r - lo * 256;
         end
         for (int j = 0; j < 3; j++) begin
            csum[j] = 0;
            dsum[j] = 0;
         end
         for (int k = 0; k < 8; k++) begin
            cx = k[0] ? c1[0] : c0[0];
            cy = k[1] ? c1[1] : c0[1];
            cz = k[2] ? c1[2] : c0[2];
            w = longint'(k[0] ? t[0] : 256 - t[0]) * (k[1] ? t[1] : 256 - t[1])
                * (k[2] ? t[2] : 256 - t[2]);
            idx = (cx * size[1] + cy) * size[2] + cz;
            for (int j = 0; j < 3; j++) begin
               csum[j] += w * colour_mem[idx][j];
               dsum[j] += w * longint'($signed(dir_mem[idx][j]));
            end
         end
         m = 0;
         for (int j = 0; j < 3; j++) begin
            s.color[j] = 16'((csum[j] + (64'd1 << 23)) >> 24);
            neg[j] = dsum[j] < 0;
            a[j] = neg[j] ? -dsum[j] : dsum[j];
            if (a[j] > m) m = a[j];
         end
         if (m != 0) begin
            // normalise magnitude into [2^23, 2^24) before the root
            while (m < (64'd1 << 23)) begin
               m <<= 1;
               for (int j = 0; j < 3; j++) a[j] <<= 1;
            end
            while (m >= (64'd1 << 24)) begin
               m >>= 1;
               for (int j = 0; j < 3; j++) a[j] >>= 1;
            end
            sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
            len = int_sqrt(sq);
            for (int j = 0; j < 3; j++) begin
               q = (64'd32768 * a[j] + len) / (2 * len);
               s.dir[j] = neg[j] ? 16'(-q) : 16'(q);
            end
         end
         return s;
      endfunction

      // accepted input transfer: update the grid or queue the sample owed
      function void note_transfer(bit op, bit [REQ_W-1:0] d);
         bit [15:0] pt [0:2];
         int idx;
         if (op == OP_LOAD) begin
            idx = d[11:0];
            loaded[idx] = 1;
            for (int j = 0; j < 3; j++) begin
               colour_mem[idx][j] = d[12 + 16*j +: 16];
               dir_mem[idx][j] = d[60 + 16*j +: 16];
            end
         end else begin
            for (int j = 0; j < 3; j++) pt[j] = d[108 + 16*j +: 16];
            awaited_samples.push_back(sample_light(pt));
         end
      endfunction

      task report(string field, bit [15:0] got, bit [15:0] want);
         $display("mismatch on %s: got %h, expected %h", field, got, want);
         mismatches++;
      endtask

      task check_sample(bit [RSP_W-1:0] d, bit fb);
         light_type want;
         string names [0:2];
         names = '{"x", "y", "z"};
         if (awaited_samples.size() == 0) begin
            report("unexpected light sample, colour x", d[15:0], 16'h0000);
            return;
         end
         want = awaited_samples.pop_front();
         for (int j = 0; j < 3; j++) begin
            if (d[16*j +: 16] != want.color[j]) report({"colour ", names[j]},
               d[16*j +: 16], want.color[j]);
            if (d[48 + 16*j +: 16] != want.dir[j]) report({"direction ", names[j]},
               d[48 + 16*j +: 16], want.dir[j]);
         end
         if (fb != want.fallback) report("used_fallback", 16'(fb), 16'(want.fallback));
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;
   logic              req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tuser;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   light_sample_checker checker_h;
   int                  sent_items;
   bit                  gaps_on;

   light_grid_trilinear_sampler DUT (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #(12 * 600000);
      $display("status: fail");
      $finish;
   end

   // receiver stall pattern: free running, random, or long stalls
   initial begin
      int mode;
      rsp_tready = 0;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(50, 300)) begin
            @(negedge clock);
            case (mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 15) == 0);
               default: rsp_tready <= ($urandom_range(0, 1) == 0);
            endcase
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) checker_h.check_sample(rsp_tdata, rsp_tuser);
   end

   task send_item(bit op, bit [REQ_W-1:0] d);
      @(negedge clock);
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      checker_h.note_transfer(op, d);
      sent_items++;
   endtask

   task pause(int n);
      @(negedge clock);
      req_tvalid <= 0;
      repeat (n) @(negedge clock);
   endtask

   // waits for every owed sample, then for a load still in the pipe
   task drain();
      pause(0);
      while (checker_h.awaited_samples.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task csr_write(reg_index_type idx, bit [31:0] value);
      @(negedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= CSR_AW'(idx) << 2;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      checker_h.write_reg(idx, value);
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
   endtask

   task set_grid(bit [15:0] ox, bit [15:0] oy, bit [15:0] oz, bit [4:0] sx, bit [4:0] sy,
                 bit [4:0] sz, bit [15:0] amb, bit rdy);
      csr_write(REG_ORIGIN_X, 32'(ox));
      csr_write(REG_ORIGIN_Y, 32'(oy));
      csr_write(REG_ORIGIN_Z, 32'(oz));
      csr_write(REG_SIZE_X, 32'(sx));
      csr_write(REG_SIZE_Y, 32'(sy));
      csr_write(REG_SIZE_Z, 32'(sz));
      csr_write(REG_AMBIENT, 32'(amb));
      csr_write(REG_GRID_READY, 32'(rdy));
   endtask

   function bit [15:0] pick_colour();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function bit [15:0] pick_dir();
      case ($urandom_range(0, 9))
         0: return 16'd16384;
         1: return -16'sd16384;
         2: return 16'd0;
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   function bit [REQ_W-1:0] load_item(int idx, bit [15:0] c [0:2], bit [15:0] v [0:2]);
      bit [REQ_W-1:0] d;
      d = '0;
      d[11:0] = 12'(idx);
      for (int j = 0; j < 3; j++) begin
         d[12 + 16*j +: 16] = c[j];
         d[60 + 16*j +: 16] = v[j];
      end
      return d;
   endfunction

   function bit [REQ_W-1:0] random_load(int idx);
      bit [15:0] c [0:2], v [0:2];
      bit [REQ_W-1:0] d;
      for (int j = 0; j < 3; j++) begin
         c[j] = pick_colour();
         v[j] = pick_dir();
      end
      d = load_item(idx, c, v);
      // junk in the unused point bits
      d[159:108] = 52'({$urandom, $urandom});
      return d;
   endfunction

   function bit [REQ_W-1:0] query_item(bit [15:0] px, bit [15:0] py, bit [15:0] pz);
      bit [REQ_W-1:0] d;
      d = {$urandom, $urandom, $urandom, $urandom, $urandom};
      d[159:108] = {4'h0, pz, py, px};
      return d;
   endfunction

   // mostly near the grid, sometimes anywhere
   function bit [15:0] pick_point(int axis);
      int span;
      if ($urandom_range(0, 7) == 0) return 16'($urandom);
      span = checker_h.size[axis] * 256 + 1024;
      return 16'(int'($signed(checker_h.origin[axis])) + $urandom_range(0, span) - 512);
   endfunction

   task random_query();
      send_item(OP_QUERY, query_item(pick_point(0), pick_point(1), pick_point(2)));
   endtask

   // loads every grid entry not yet written
   task fill_grid();
      int prod;
      prod = checker_h.size[0] * checker_h.size[1] * checker_h.size[2];
      for (int i = 0; i < prod; i++)
         if (!checker_h.loaded[i]) send_item(OP_LOAD, random_load(i));
   endtask

   task random_phase();
      bit [15:0] org [0:2];
      bit [4:0]  sz [0:2];
      int        prod, burst;
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 9))
            0: org[i] = 16'h8000;
            1: org[i] = 16'h7fff;
            2: org[i] = 16'h0000;
            default: org[i] = 16'($urandom);
         endcase
         case ($urandom_range(0, 11))
            0: sz[i] = 5'd16;
            1: sz[i] = 5'd1;
            default: sz[i] = 5'($urandom_range(1, 4));
         endcase
      end
      // keep the grid small unless one axis is long
      if (sz[0] * sz[1] * sz[2] > 256) sz[2] = 5'd1;
      case ($urandom_range(0, 9))
         0: sz[$urandom_range(0, 2)] = 5'd0;
         1: sz[$urandom_range(0, 2)] = 5'($urandom_range(17, 31));
         default: ;
      endcase
      set_grid(org[0], org[1], org[2], sz[0], sz[1], sz[2], 16'($urandom),
               $urandom_range(0, 7) != 0);
      gaps_on = $urandom_range(0, 2) != 0;
      prod = sz[0] * sz[1] * sz[2];
      if (checker_h.grid_usable()) fill_grid();
      burst = 0;
      repeat (40) begin
         if (checker_h.grid_usable() && $urandom_range(0, 9) < 3)
            send_item(OP_LOAD, random_load($urandom_range(0, 9) == 0 ?
                                           $urandom_range(0, 4095) :
                                           $urandom_range(0, prod - 1)));
         else
            random_query();
         if (burst == 0) begin
            burst = $urandom_range(1, 16);
            if (gaps_on) pause($urandom_range(0, 6));
         end
         burst--;
      end
      drain();
   endtask

   initial begin
      bit [15:0] c [0:2], v [0:2];
      checker_h = new();
      sent_items = 0;
      reset = 1;
      req_tvalid = 0;
      req_tuser = 0;
      req_tdata = '0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // no grid after reset, then full ambient
      send_item(OP_QUERY, query_item(16'h0000, 16'h0000, 16'h0000));
      drain();
      csr_write(REG_AMBIENT, 32'hffff);
      send_item(OP_QUERY, query_item(16'h7fff, 16'h8000, 16'h1234));
      drain();

      // 2x2x2 grid of extreme entries
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 3; j++) begin
            c[j] = i[j] ? 16'hffff : 16'h0000;
            v[j] = i[(j + 1) % 3] ? 16'd16384 : -16'sd16384;
         end
         send_item(OP_LOAD, load_item(i, c, v));
      end
      drain();
      set_grid(16'h0000, 16'h0000, 16'h0000, 5'd2, 5'd2, 5'd2, 16'h0800, 1'b1);
      send_item(OP_QUERY, query_item(16'h0000, 16'h0000, 16'h0000));
      send_item(OP_QUERY, query_item(16'h0100, 16'h0100, 16'h0100));
      send_item(OP_QUERY, query_item(16'h0080, 16'h0040, 16'h00c0));
      send_item(OP_QUERY, query_item(16'h7fff, 16'h7fff, 16'h7fff));
      send_item(OP_QUERY, query_item(16'h8000, 16'h8000, 16'h8000));
      send_item(OP_QUERY, query_item(16'h0080, 16'h0080, 16'h0080));

      // zero directions blend to a zero direction
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 3; j++) begin
            c[j] = 16'h1000;
            v[j] = 16'h0000;
         end
         send_item(OP_LOAD, load_item(i, c, v));
      end
      send_item(OP_QUERY, query_item(16'h0040, 16'h0040, 16'h0040));
      drain();

      // single sample on every axis, and an oversized axis
      set_grid(16'h8000, 16'h7fff, 16'h0100, 5'd1, 5'd1, 5'd1, 16'h0000, 1'b1);
      send_item(OP_QUERY, query_item(16'h0000, 16'h0000, 16'h0000));
      drain();
      set_grid(16'h0000, 16'h0000, 16'h0000, 5'd16, 5'd16, 5'd16, 16'hffff, 1'b0);
      send_item(OP_QUERY, query_item(16'h0000, 16'h0000, 16'h0000));
      drain();
      csr_write(REG_SIZE_X, 32'd31);
      send_item(OP_QUERY, query_item(16'h0000, 16'h0000, 16'h0000));
      drain();

      while (sent_items < 750) random_phase();

      // back-to-back traffic on an all-ready grid with no gaps
      set_grid(16'h0000, 16'h0000, 16'h0000, 5'd3, 5'd3, 5'd3, 16'h0000, 1'b1);
      fill_grid();
      repeat (20) random_query();
      drain();

      if (checker_h.mismatches == 0 && checker_h.awaited_samples.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
